>>> rtl/cmbc_pkg.sv
// Shared types, constants and helper functions for the CAN message buffer controller.
// No dependencies; used by cmbc_ctrl, cmbc_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package cmbc_pkg;

    localparam int REG_WORDS_DEF  = 1024;
    localparam int MB_BUFFERS_DEF = 96;

    // request kinds carried in tuser
    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_RX    = 2'd2;

    // control word indexes held in flops (below the buffer area)
    localparam logic [4:0] W_MODE  = 5'd0;
    localparam logic [4:0] W_CTRL1 = 5'd1;
    localparam logic [4:0] W_GMASK = 5'd4;
    localparam logic [4:0] W_ERRST = 5'd8;
    localparam logic [4:0] W_IMASK = 5'd10;
    localparam logic [4:0] W_FLAGS = 5'd12;
    localparam logic [4:0] W_STAT0 = 5'd14;
    localparam logic [4:0] W_STAT1 = 5'd17;
    localparam logic [4:0] W_STAT2 = 5'd19;

    localparam logic [15:0] STAT_ADDR3 = 16'h0C08;
    localparam logic [15:0] BUF_START  = 16'h0080;
    localparam logic [31:0] MODE_RST   = 32'hD900_000F;
    localparam logic [3:0]  CODE_EMPTY = 4'h4;
    localparam logic [3:0]  CODE_SEND  = 4'hC;
    localparam logic [31:0] FULL_WORD  = 32'h0200_0000;
    localparam logic [31:0] CS_KEEP    = 32'h00FF_0000;
    localparam int          LPB_BIT    = 12;

    // memory address select
    localparam logic [1:0] AS_CLR = 2'd0;
    localparam logic [1:0] AS_ACC = 2'd1;
    localparam logic [1:0] AS_TXW = 2'd2;
    localparam logic [1:0] AS_SCN = 2'd3;

    // memory write data select
    localparam logic [1:0] WS_ZERO   = 2'd0;
    localparam logic [1:0] WS_MERGED = 2'd1;
    localparam logic [1:0] WS_BUF    = 2'd2;

    typedef struct packed {
        logic       ready;
        logic       in_load;
        logic       rd_en;
        logic       mem_we;
        logic [1:0] addr_sel;
        logic [1:0] word_k;
        logic [1:0] wsel;
        logic       ctl_wr;
        logic       cs_load;
        logic       id_load;
        logic       d0_load;
        logic       d1_load;
        logic       scan_clr;
        logic       scan_inc;
        logic       flag_rx;
        logic       flag_tx;
        logic       tx_set;
        logic       out_load;
        logic       clr_inc;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       in_win;
        logic       low;
        logic       stat_word;
        logic       tx_hit;
        logic       err;
        logic       bus_tx;
        logic       lpb;
        logic       empty;
        logic       match;
        logic       skip;
        logic       scan_end;
        logic       clr_done;
        logic       out_busy;
    } stat_t;

    function automatic logic [31:0] lane_mask(input logic [2:0] sz);
        logic [31:0] m;
        case (sz)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // keeps the first len bytes counted from the top
    function automatic logic [63:0] top_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[63-8*i -: 8] = (len > 4'(i)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [3:0] cap_len(input logic [3:0] len);
        return (len > 4'd8) ? 4'd8 : len;
    endfunction

    // freeze/disable acknowledge recompute
    function automatic logic [31:0] settle_mode(input logic [31:0] mi);
        logic [31:0] m;
        m = mi & ~32'h0900_0000 & ~32'h0010_0000;
        if (m[30] && m[28]) begin
            m[24] = 1'b1;
            m[27] = 1'b1;
        end
        if (m[31]) begin
            m[20] = 1'b1;
            m[27] = 1'b1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cmbc_ctrl.sv
// Sequencer for the CAN message buffer controller: access decode, transmit, buffer scan.
// Depends on cmbc_pkg; drives the cmbc_dp datapath through cmd_t / stat_t.
`timescale 1ns / 1ps
`default_nettype none
module cmbc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire cmbc_pkg::stat_t st,
    output cmbc_pkg::cmd_t      cmd
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_MERGE = 5'd3;
    localparam logic [4:0] S_TX1   = 5'd4;
    localparam logic [4:0] S_TX2   = 5'd5;
    localparam logic [4:0] S_TX3   = 5'd6;
    localparam logic [4:0] S_TX4   = 5'd7;
    localparam logic [4:0] S_SC_CS = 5'd8;
    localparam logic [4:0] S_SC_CK = 5'd9;
    localparam logic [4:0] S_SC_ID = 5'd10;
    localparam logic [4:0] S_WB0   = 5'd11;
    localparam logic [4:0] S_WB1   = 5'd12;
    localparam logic [4:0] S_WB2   = 5'd13;
    localparam logic [4:0] S_WB3   = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = cmbc_pkg::AS_CLR;
                cmd.wsel     = cmbc_pkg::WS_ZERO;
                cmd.clr_inc  = 1'b1;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                cmd.ready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = cmbc_pkg::AS_ACC;
                if (st.func == cmbc_pkg::FN_WRITE && st.in_win) begin
                    if (st.low) begin
                        cmd.ctl_wr = 1'b1;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_MERGE;
                    end
                end else if (st.func == cmbc_pkg::FN_RX && !st.err) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SC_CS;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_MERGE: begin
                cmd.addr_sel = cmbc_pkg::AS_ACC;
                cmd.wsel     = cmbc_pkg::WS_MERGED;
                cmd.mem_we   = !st.stat_word;
                cmd.cs_load  = 1'b1;
                state_next   = st.tx_hit ? S_TX1 : S_FIN;
            end
            S_TX1: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = cmbc_pkg::AS_TXW;
                cmd.word_k   = 2'd1;
                state_next   = S_TX2;
            end
            S_TX2: begin
                cmd.id_load  = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = cmbc_pkg::AS_TXW;
                cmd.word_k   = 2'd2;
                state_next   = S_TX3;
            end
            S_TX3: begin
                cmd.d0_load  = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = cmbc_pkg::AS_TXW;
                cmd.word_k   = 2'd3;
                state_next   = S_TX4;
            end
            S_TX4: begin
                cmd.d1_load = 1'b1;
                if (st.bus_tx) begin
                    cmd.tx_set  = 1'b1;
                    cmd.flag_tx = 1'b1;
                    state_next  = S_FIN;
                end else if (st.lpb) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SC_CS;
                end else begin
                    cmd.flag_tx = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_SC_CS: begin
                if (st.scan_end) begin
                    cmd.flag_tx = (st.func == cmbc_pkg::FN_WRITE);
                    state_next  = S_FIN;
                end else if (st.skip) begin
                    cmd.scan_inc = 1'b1;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = cmbc_pkg::AS_SCN;
                    state_next   = S_SC_CK;
                end
            end
            S_SC_CK: begin
                if (!st.empty) begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SC_CS;
                end else if (st.func == cmbc_pkg::FN_RX) begin
                    state_next = S_WB0;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = cmbc_pkg::AS_SCN;
                    cmd.word_k   = 2'd1;
                    state_next   = S_SC_ID;
                end
            end
            S_SC_ID: begin
                if (st.match) begin
                    state_next = S_WB0;
                end else begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SC_CS;
                end
            end
            S_WB0, S_WB1, S_WB2, S_WB3: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = cmbc_pkg::AS_SCN;
                cmd.wsel     = cmbc_pkg::WS_BUF;
                cmd.word_k   = 2'(state_reg - S_WB0);
                state_next   = state_reg + 5'd1;
                if (state_reg == S_WB3) begin
                    cmd.flag_rx = 1'b1;
                    cmd.flag_tx = (st.func == cmbc_pkg::FN_WRITE);
                    state_next  = S_FIN;
                end
            end
            S_FIN: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/cmbc_dp.sv
// Datapath of the CAN message buffer controller: register memory, control flops,
// frame holding registers and the result register. Depends on cmbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmbc_dp #(
    parameter int REG_WORDS  = cmbc_pkg::REG_WORDS_DEF,
    parameter int MB_BUFFERS = cmbc_pkg::MB_BUFFERS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic           cfg_wr_data,
    input  wire logic [1:0]     in_func,
    input  wire logic [15:0]    in_address,
    input  wire logic [31:0]    in_write_data,
    input  wire logic [2:0]     in_access_bytes,
    input  wire logic [28:0]    in_frame_id,
    input  wire logic           in_frame_ext,
    input  wire logic           in_frame_rtr,
    input  wire logic           in_frame_err,
    input  wire logic [3:0]     in_frame_len,
    input  wire logic [63:0]    in_frame_data,
    input  wire cmbc_pkg::cmd_t cmd,
    output cmbc_pkg::stat_t     st,
    input  wire logic           m_tready,
    output logic                m_tvalid,
    output logic [31:0]         out_read_data,
    output logic                out_irq_level,
    output logic                out_tx_valid,
    output logic [28:0]         out_tx_id,
    output logic                out_tx_ext,
    output logic                out_tx_rtr,
    output logic [3:0]          out_tx_len,
    output logic [63:0]         out_tx_data
);

    localparam int AW  = $clog2(REG_WORDS);
    localparam int MBW = $clog2(MB_BUFFERS + 1);
    localparam logic [16:0] WIN_END = 17'(4 * REG_WORDS);
    localparam logic [16:0] BUF_END = 17'(32'h80 + 16 * MB_BUFFERS);

    logic [31:0] mem [REG_WORDS];
    logic [31:0] rdata_reg;
    logic [31:0] ctl_reg [32];

    logic [1:0]     func_reg;
    logic [15:0]    addr_reg;
    logic [31:0]    wd_reg;
    logic [2:0]     sz_reg;
    logic           err_reg;
    logic [31:0]    cs_reg, id_reg, d0_reg, d1_reg;
    logic [MBW-1:0] tx_reg, scan_reg;
    logic [AW-1:0]  clr_reg;
    logic           txv_reg;
    logic           bus_reg;
    logic           mvalid_reg;

    logic [4:0]    shift;
    logic [31:0]   lm, msk, val, old, merged, rd_res, wdata, fl_set;
    logic [AW-1:0] maddr, tx_base, sc_base;
    logic [3:0]    rx_len, tx_len;
    logic [63:0]   rx_data;
    logic          in_win;

    assign shift   = {addr_reg[1:0], 3'b000};
    assign lm      = cmbc_pkg::lane_mask(sz_reg);
    assign msk     = (sz_reg >= 3'd4) ? 32'hFFFF_FFFF : (lm << shift);
    assign val     = wd_reg << shift;
    assign old     = (addr_reg[15:7] == '0) ? ctl_reg[addr_reg[6:2]] : rdata_reg;
    assign merged  = (old & ~msk) | (val & msk);
    assign in_win  = {1'b0, addr_reg} < WIN_END;
    assign rd_res  = st.stat_word ? 32'h0 : ((old >> shift) & lm);

    assign tx_base = AW'(32) + AW'({tx_reg, 2'b00});
    assign sc_base = AW'(32) + AW'({scan_reg, 2'b00});

    always_comb begin
        case (cmd.addr_sel)
            cmbc_pkg::AS_CLR: maddr = clr_reg;
            cmbc_pkg::AS_ACC: maddr = addr_reg[AW+1:2];
            cmbc_pkg::AS_TXW: maddr = tx_base + AW'(cmd.word_k);
            default:          maddr = sc_base + AW'(cmd.word_k);
        endcase
        case (cmd.wsel)
            cmbc_pkg::WS_MERGED: wdata = merged;
            cmbc_pkg::WS_BUF: begin
                case (cmd.word_k)
                    2'd0:    wdata = cmbc_pkg::FULL_WORD | (cs_reg & cmbc_pkg::CS_KEEP);
                    2'd1:    wdata = id_reg;
                    2'd2:    wdata = d0_reg;
                    default: wdata = d1_reg;
                endcase
            end
            default: wdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) mem[maddr] <= wdata;
        if (cmd.rd_en) rdata_reg <= mem[maddr];
    end

    // status to the sequencer
    always_comb begin
        st.func      = func_reg;
        st.in_win    = in_win;
        st.low       = (addr_reg[15:7] == '0);
        st.stat_word = (addr_reg[15:7] == '0 &&
                        (addr_reg[6:2] == cmbc_pkg::W_STAT0 ||
                         addr_reg[6:2] == cmbc_pkg::W_STAT1 ||
                         addr_reg[6:2] == cmbc_pkg::W_STAT2)) ||
                       ({addr_reg[15:2], 2'b00} == cmbc_pkg::STAT_ADDR3);
        st.tx_hit    = (addr_reg >= cmbc_pkg::BUF_START) && ({1'b0, addr_reg} < BUF_END) &&
                       (addr_reg[3:0] == 4'h0) && (merged[27:24] == cmbc_pkg::CODE_SEND);
        st.err       = err_reg;
        st.lpb       = ctl_reg[cmbc_pkg::W_CTRL1][cmbc_pkg::LPB_BIT];
        st.bus_tx    = bus_reg && !st.lpb;
        st.empty     = (rdata_reg[27:24] == cmbc_pkg::CODE_EMPTY);
        st.match     = ((id_reg ^ rdata_reg) & ctl_reg[cmbc_pkg::W_GMASK]) == 32'h0;
        st.skip      = (func_reg == cmbc_pkg::FN_WRITE) && (scan_reg == tx_reg);
        st.scan_end  = (scan_reg == MBW'(MB_BUFFERS));
        st.clr_done  = (clr_reg == AW'(REG_WORDS - 1));
        st.out_busy  = mvalid_reg && !m_tready;
    end

    assign fl_set = ((cmd.flag_rx && scan_reg < MBW'(32)) ? (32'd1 << scan_reg) : 32'h0) |
                    ((cmd.flag_tx && tx_reg < MBW'(32)) ? (32'd1 << tx_reg) : 32'h0);

    // control words below the buffer area
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) begin
                ctl_reg[i] <= (i == 0) ? cmbc_pkg::MODE_RST : 32'h0;
            end
        end else if (cmd.ctl_wr) begin
            case (addr_reg[6:2])
                cmbc_pkg::W_MODE:
                    ctl_reg[cmbc_pkg::W_MODE] <= cmbc_pkg::settle_mode(merged & ~32'h0200_0000);
                cmbc_pkg::W_ERRST, cmbc_pkg::W_FLAGS:
                    ctl_reg[addr_reg[6:2]] <= old & ~(val & msk);
                cmbc_pkg::W_STAT0, cmbc_pkg::W_STAT1, cmbc_pkg::W_STAT2: ;
                default: ctl_reg[addr_reg[6:2]] <= merged;
            endcase
        end else if (cmd.flag_rx || cmd.flag_tx) begin
            ctl_reg[cmbc_pkg::W_FLAGS] <= ctl_reg[cmbc_pkg::W_FLAGS] | fl_set;
        end
    end

    assign rx_len  = cmbc_pkg::cap_len(in_frame_len);
    assign rx_data = in_frame_data & cmbc_pkg::top_mask(rx_len);
    assign tx_len  = cmbc_pkg::cap_len(cs_reg[19:16]);

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            func_reg <= in_func;
            addr_reg <= in_address;
            wd_reg   <= in_write_data;
            sz_reg   <= in_access_bytes;
            err_reg  <= in_frame_err;
            id_reg   <= in_frame_ext ? {3'b000, in_frame_id}
                                     : {3'b000, in_frame_id[10:0], 18'h0};
            cs_reg   <= {cmbc_pkg::FULL_WORD[31:24], 1'b0, in_frame_ext, in_frame_ext,
                         in_frame_rtr, rx_len, 16'h0};
            d0_reg   <= rx_data[63:32];
            d1_reg   <= rx_data[31:0];
        end else begin
            if (cmd.cs_load) begin
                cs_reg <= merged;
                tx_reg <= MBW'((addr_reg - cmbc_pkg::BUF_START) >> 4);
            end
            if (cmd.id_load) id_reg <= rdata_reg;
            if (cmd.d0_load) d0_reg <= rdata_reg;
            if (cmd.d1_load) d1_reg <= rdata_reg;
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
        end else if (cmd.scan_inc) begin
            scan_reg <= scan_reg + MBW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            bus_reg    <= 1'b0;
            txv_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr_inc) clr_reg <= clr_reg + AW'(1);
            if (cfg_wr_en) bus_reg <= cfg_wr_data;
            if (cmd.in_load) begin
                txv_reg <= 1'b0;
            end else if (cmd.tx_set) begin
                txv_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_read_data <= (func_reg == cmbc_pkg::FN_READ && in_win) ? rd_res : 32'h0;
            out_irq_level <= (ctl_reg[cmbc_pkg::W_FLAGS] & ctl_reg[cmbc_pkg::W_IMASK]) != 0;
            out_tx_valid  <= txv_reg;
            out_tx_id     <= !txv_reg ? 29'h0 :
                             cs_reg[21] ? id_reg[28:0] : {18'h0, id_reg[28:18]};
            out_tx_ext    <= txv_reg && cs_reg[21];
            out_tx_rtr    <= txv_reg && cs_reg[20];
            out_tx_len    <= txv_reg ? tx_len : 4'h0;
            out_tx_data   <= txv_reg ? ({d0_reg, d1_reg} & cmbc_pkg::top_mask(tx_len))
                                     : 64'h0;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule
`default_nettype wire

>>> rtl/can_message_buffer_controller_unit.sv
// Top level of the CAN message buffer controller: stream ports and packing.
// Depends on cmbc_pkg, cmbc_ctrl and cmbc_dp.
`timescale 1ns / 1ps
`default_nettype none
// Register-mapped CAN controller with message buffers. Each input transaction is a
// register read, a register write or a frame arriving from the bus (s_tuser); each
// one yields exactly one result transaction holding the read data, the interrupt
// level and, when a frame went out on the bus, the sent frame. After reset the
// block clears its register memory and takes no input in that time. One transaction
// at a time is processed: a read, or a write of the control words below offset 0x80,
// finishes after decode; other register writes read, merge and write back the memory
// word, and a transmit write adds reads of the buffer words. Receive and loopback scan
// the buffers through the single memory port, reading each control word and, in
// loopback, the ID of an empty buffer, then fill the chosen buffer. A finished result
// waits in its own register, so the next transaction is taken while it is still unread.
module can_message_buffer_controller_unit #(
    parameter int REG_WORDS  = cmbc_pkg::REG_WORDS_DEF,
    parameter int MB_BUFFERS = cmbc_pkg::MB_BUFFERS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // bus_connected register
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // address[15:0] write_data[47:16] access_bytes[50:48] frame_id[79:51]
    // frame_ext[80] frame_rtr[81] frame_err[82] frame_len[86:83] frame_data[150:87]
    input  wire logic [151:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // read_data[31:0] irq_level[32] tx_id[61:33] tx_ext[62] tx_rtr[63]
    // tx_len[67:64] tx_data[131:68]
    output logic [135:0]      m_tdata,
    // tx_valid[0]
    output logic              m_tuser
);

    cmbc_pkg::cmd_t  cmd;
    cmbc_pkg::stat_t st;

    logic [31:0] read_data;
    logic        irq_level;
    logic [28:0] tx_id;
    logic        tx_ext, tx_rtr;
    logic [3:0]  tx_len;
    logic [63:0] tx_data;

    // sequencer: decode, transmit, buffer scan and write-back
    cmbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd)
    );

    // register memory, control words and result register
    cmbc_dp #(
        .REG_WORDS  (REG_WORDS),
        .MB_BUFFERS (MB_BUFFERS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_func         (s_tuser),
        .in_address      (s_tdata[15:0]),
        .in_write_data   (s_tdata[47:16]),
        .in_access_bytes (s_tdata[50:48]),
        .in_frame_id     (s_tdata[79:51]),
        .in_frame_ext    (s_tdata[80]),
        .in_frame_rtr    (s_tdata[81]),
        .in_frame_err    (s_tdata[82]),
        .in_frame_len    (s_tdata[86:83]),
        .in_frame_data   (s_tdata[150:87]),
        .cmd             (cmd),
        .st              (st),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_read_data   (read_data),
        .out_irq_level   (irq_level),
        .out_tx_valid    (m_tuser),
        .out_tx_id       (tx_id),
        .out_tx_ext      (tx_ext),
        .out_tx_rtr      (tx_rtr),
        .out_tx_len      (tx_len),
        .out_tx_data     (tx_data)
    );

    assign s_tready = cmd.ready;
    assign m_tdata  = {4'h0, tx_data, tx_len, tx_rtr, tx_ext, tx_id, irq_level, read_data};

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the CAN message buffer controller top level.
// Depends on cmbc_pkg and can_message_buffer_controller_unit; nothing else.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import cmbc_pkg::*;

    localparam int LIMIT = 20000;   // idle cycles before the watchdog trips
    localparam int NBUF  = 96;

    localparam logic [1:0]  FN_NONE   = 2'd3;
    localparam logic [15:0] A_MODE    = 16'h0000;
    localparam logic [15:0] A_CTRL1   = 16'h0004;
    localparam logic [15:0] A_GMASK   = 16'h0010;
    localparam logic [15:0] A_ERRST   = 16'h0020;
    localparam logic [15:0] A_IMASK   = 16'h0028;
    localparam logic [15:0] A_FLAGS   = 16'h0030;
    localparam logic [15:0] A_STS0    = 16'h0038;
    localparam logic [15:0] A_STS1    = 16'h0044;
    localparam logic [15:0] A_STS2    = 16'h004C;
    localparam logic [3:0]  CODE_FULL = 4'h2;
    localparam logic [31:0] B_SRR     = 32'h0040_0000;
    localparam logic [31:0] B_IDE     = 32'h0020_0000;
    localparam logic [31:0] B_RTR     = 32'h0010_0000;
    localparam logic [31:0] B_LOOP    = 32'h0000_1000;

    typedef struct {
        logic [1:0]  fn;
        logic [15:0] addr;
        logic [31:0] wd;
        logic [2:0]  sz;
        logic [28:0] fid;
        logic        fext, frtr, ferr;
        logic [3:0]  flen;
        logic [63:0] fdata;
        bit          lit;      // expectation typed in by hand
        logic [31:0] lit_rd;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        txv;
        logic [28:0] tid;
        logic        text;
        logic        trtr;
        logic [3:0]  tlen;
        logic [63:0] tdat;
    } resp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_wr_data = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;

    can_message_buffer_controller_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------
    // Shadow of the register file and the transaction predictor
    // ---------------------------------------------------------------------------
    logic [31:0] regs [0:REG_WORDS_DEF-1];
    logic        bus_att = 1'b0;
    resp_t       cur;
    resp_t       resp_q [$];
    int          errors = 0;
    int          n_rd = 0, n_wr = 0, n_fr = 0, n_bus = 0, n_loop = 0, n_rx = 0, n_resp = 0;
    bit          no_idle = 1'b0;

    function automatic logic [31:0] word_at(int i);
        return (i < REG_WORDS_DEF) ? regs[i] : 32'h0;
    endfunction

    function automatic void put_word(int i, logic [31:0] v);
        if (i < REG_WORDS_DEF) regs[i] = v;
    endfunction

    function automatic void flag_buf(int b);
        // only the first 32 buffers own a flag bit
        if (b < 32) regs[W_FLAGS] = regs[W_FLAGS] | (32'h1 << b);
    endfunction

    function automatic logic [31:0] byte_lanes(logic [2:0] sz);
        case (sz)
            3'd0:    return 32'h0000_0000;
            3'd1:    return 32'h0000_00FF;
            3'd2:    return 32'h0000_FFFF;
            3'd3:    return 32'h00FF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [63:0] head_bytes(logic [63:0] d, logic [3:0] len);
        if (len == 4'd0) return 64'h0;
        return d & (~64'h0 << (64 - 8 * len));
    endfunction

    function automatic logic [31:0] mode_ack(logic [31:0] mi);
        logic [31:0] m;
        m = mi & ~32'h0910_0000;
        if (m[30] && m[28]) m = m | 32'h0900_0000;
        if (m[31]) m = m | 32'h0810_0000;
        return m;
    endfunction

    function automatic void send_buf(int tx);
        int          t, r;
        logic [31:0] cs, id, msk, rc;
        logic [3:0]  len;
        logic        lpb;
        t   = (32'h80 + tx * 16) >> 2;
        cs  = word_at(t);
        id  = word_at(t + 1);
        lpb = (word_at(W_CTRL1) & B_LOOP) != 0;
        if (bus_att && !lpb) begin
            len = (cs[19:16] > 4'd8) ? 4'd8 : cs[19:16];
            cur.txv  = 1'b1;
            cur.tid  = cs[21] ? id[28:0] : {18'h0, id[28:18]};
            cur.text = cs[21];
            cur.trtr = cs[20];
            cur.tlen = len;
            cur.tdat = head_bytes({word_at(t + 2), word_at(t + 3)}, len);
            n_bus++;
        end else if (lpb) begin
            msk = word_at(W_GMASK);
            for (int rx = 0; rx < NBUF; rx++) begin
                r  = (32'h80 + rx * 16) >> 2;
                rc = word_at(r);
                if (rx == tx || rc[27:24] != CODE_EMPTY) continue;
                if (((id ^ word_at(r + 1)) & msk) != 0) continue;
                put_word(r, {4'h0, CODE_FULL, 24'h0} | (cs & CS_KEEP));
                put_word(r + 1, id);
                put_word(r + 2, word_at(t + 2));
                put_word(r + 3, word_at(t + 3));
                flag_buf(rx);
                n_loop++;
                break;
            end
        end
        flag_buf(tx);
    endfunction

    function automatic void take_frame(req_t it);
        int          r;
        logic [31:0] rc;
        logic [3:0]  len;
        logic [63:0] d;
        if (it.ferr) return;
        len = (it.flen > 4'd8) ? 4'd8 : it.flen;
        d   = head_bytes(it.fdata, len);
        for (int rx = 0; rx < NBUF; rx++) begin
            r  = (32'h80 + rx * 16) >> 2;
            rc = word_at(r);
            if (rc[27:24] != CODE_EMPTY) continue;
            put_word(r + 1, it.fext ? {3'h0, it.fid} : ({21'h0, it.fid[10:0]} << 18));
            put_word(r + 2, d[63:32]);
            put_word(r + 3, d[31:0]);
            put_word(r, {4'h0, CODE_FULL, 4'h0, len, 16'h0} |
                        (it.fext ? (B_IDE | B_SRR) : 32'h0) | (it.frtr ? B_RTR : 32'h0));
            flag_buf(rx);
            n_rx++;
            return;
        end
    endfunction

    function automatic bit is_status(logic [15:0] wa);
        return wa == A_STS0 || wa == A_STS1 || wa == A_STS2 || wa == STAT_ADDR3;
    endfunction

    function automatic void reg_write(logic [15:0] addr, logic [31:0] wd, logic [2:0] sz);
        int          idx, sh;
        logic [15:0] wa;
        logic [31:0] m, v, merged;
        idx    = addr >> 2;
        wa     = addr & ~16'h3;
        sh     = addr[1:0] * 8;
        m      = (sz >= 3'd4) ? 32'hFFFF_FFFF : (byte_lanes(sz) << sh);
        v      = wd << sh;
        merged = (word_at(idx) & ~m) | (v & m);
        if (wa == A_MODE) begin
            put_word(idx, mode_ack(merged & ~32'h0200_0000));
        end else if (wa == A_ERRST || wa == A_FLAGS) begin
            put_word(idx, word_at(idx) & ~(v & m));
        end else if (!is_status(wa)) begin
            put_word(idx, merged);
            if (addr >= BUF_START && addr < BUF_START + NBUF * 16 && addr[3:0] == 4'h0 &&
                merged[27:24] == CODE_SEND)
                send_buf((addr - BUF_START) / 16);
        end
    endfunction

    function automatic resp_t predict_resp(req_t it);
        logic [31:0] v;
        bit          inw;
        cur = '0;
        inw = it.addr < REG_WORDS_DEF * 4;
        if (it.fn == FN_READ && inw) begin
            v = is_status(it.addr & ~16'h3) ? 32'h0 : word_at(it.addr >> 2);
            cur.rdata = (v >> (it.addr[1:0] * 8)) & byte_lanes(it.sz);
        end else if (it.fn == FN_WRITE && inw) begin
            reg_write(it.addr, it.wd, it.sz);
        end else if (it.fn == FN_RX) begin
            take_frame(it);
        end
        cur.irq = (regs[W_FLAGS] & regs[W_IMASK]) != 0;
        return cur;
    endfunction

    // ---------------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------------
    task automatic push_req(req_t it);
        int    gap;
        resp_t r;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.fn;
        s_tdata  <= {1'b0, it.fdata, it.flen, it.ferr, it.frtr, it.fext, it.fid,
                     it.sz, it.wd, it.addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transaction taken at this edge
        r = predict_resp(it);
        if (it.lit) r = '{rdata: it.lit_rd, default: '0};
        resp_q.push_back(r);
        case (it.fn)
            FN_READ:  n_rd++;
            FN_WRITE: n_wr++;
            FN_RX:    n_fr++;
            default:  ;
        endcase
    endtask

    function automatic req_t mk(logic [1:0] fn, logic [15:0] addr, logic [31:0] wd,
                                logic [2:0] sz);
        req_t it;
        it = '{fn: fn, addr: addr, wd: wd, sz: sz, fid: '0, fext: 1'b0, frtr: 1'b0,
               ferr: 1'b0, flen: '0, fdata: '0, lit: 1'b0, lit_rd: '0};
        return it;
    endfunction

    function automatic req_t mk_frame(logic [28:0] id, logic ext, logic rtr, logic err,
                                      logic [3:0] len, logic [63:0] d);
        req_t it;
        it = mk(FN_RX, 16'h0, 32'h0, 3'd0);
        it.fid = id; it.fext = ext; it.frtr = rtr; it.ferr = err;
        it.flen = len; it.fdata = d;
        return it;
    endfunction

    function automatic req_t mk_lit(logic [15:0] addr, logic [2:0] sz, logic [31:0] rd);
        req_t it;
        it = mk(FN_READ, addr, 32'h0, sz);
        it.lit = 1'b1; it.lit_rd = rd;
        return it;
    endfunction

    function automatic logic [15:0] ctl_of(int b);
        return BUF_START + 16'(b * 16);
    endfunction

    function automatic int pick_buf();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, NBUF - 1)
                                           : $urandom_range(0, 15);
    endfunction

    function automatic logic [2:0] pick_sz();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
    endfunction

    // random item: mostly buffer set-up, transmit and receive sequences
    function automatic req_t rand_req();
        int          k, b;
        logic [31:0] w;
        k = $urandom_range(0, 99);
        b = pick_buf();
        w = $urandom;
        if (k < 18)
            return mk(FN_WRITE, ctl_of(b), {4'h0, CODE_EMPTY, w[23:0]}, 3'd4);
        if (k < 28)
            return mk(FN_WRITE, ctl_of(b) + 16'h4,
                      ($urandom_range(0, 1) == 1) ? w : 32'h0, pick_sz());
        if (k < 36)
            return mk(FN_WRITE, ctl_of(b) + 16'(8 + 4 * $urandom_range(0, 1)), w, pick_sz());
        if (k < 48)
            return mk(FN_WRITE, ctl_of(b), {4'h0, CODE_SEND, w[23:0]}, 3'd4);
        if (k < 64)
            return mk_frame(29'($urandom), w[0], w[1], $urandom_range(0, 9) == 0,
                            4'($urandom_range(0, 15)), {$urandom, $urandom});
        if (k < 74)
            return mk(FN_READ, 16'($urandom_range(0, 16'h6FF)), w, pick_sz());
        if (k < 84) begin
            case ($urandom_range(0, 5))
                0: return mk(FN_WRITE, A_MODE, w, pick_sz());
                1: return mk(FN_WRITE, A_CTRL1, w & ~B_LOOP | (w[31] ? B_LOOP : 0), 3'd4);
                2: return mk(FN_WRITE, A_GMASK, w[0] ? 32'h0 : (w[1] ? ~32'h0 : w), 3'd4);
                3: return mk(FN_WRITE, A_IMASK, w, 3'd4);
                4: return mk(FN_WRITE, A_FLAGS, w, pick_sz());
                default: return mk(FN_WRITE, A_ERRST, w, pick_sz());
            endcase
        end
        if (k < 94) begin
            // noise: any function, any address, any size
            req_t it;
            it = mk(2'($urandom_range(0, 3)), 16'($urandom), w, 3'($urandom_range(0, 7)));
            it.fid = 29'($urandom); it.fext = w[3]; it.frtr = w[4];
            it.ferr = w[5]; it.flen = w[9:6]; it.fdata = {$urandom, $urandom};
            return it;
        end
        case ($urandom_range(0, 4))
            0: return mk(FN_READ, A_STS0, w, 3'd4);
            1: return mk(FN_READ, A_STS2 + 16'(w[1:0]), w, pick_sz());
            2: return mk(FN_READ, STAT_ADDR3, w, 3'd4);
            3: return mk(FN_READ, A_FLAGS, w, 3'd4);
            default: return mk(FN_WRITE, 16'($urandom_range(16'h1000, 16'hFFFF)), w, 3'd4);
        endcase
    endfunction

    task automatic set_bus(logic v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        bus_att = v;
    endtask

    // let every result drain, then allow a full buffer scan for silent items
    task automatic drain();
        s_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------------
    // Receiver side: stalls and field-by-field checking
    // ---------------------------------------------------------------------------
    int stall_left = 0;

    task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        resp_t e;
        int    n;
        if (!aresetn) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_resp++;
                if (resp_q.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, m_tdata);
                    errors++;
                end else begin
                    e = resp_q.pop_front();
                    cmp("read_data", e.rdata, m_tdata[31:0]);
                    cmp("irq_level", e.irq, m_tdata[32]);
                    cmp("tx_valid", e.txv, m_tuser);
                    cmp("tx_id", e.tid, m_tdata[61:33]);
                    cmp("tx_ext", e.text, m_tdata[62]);
                    cmp("tx_rtr", e.trtr, m_tdata[63]);
                    cmp("tx_len", e.tlen, m_tdata[67:64]);
                    cmp("tx_data", e.tdat, m_tdata[131:68]);
                end
                n = no_idle ? 0 : $urandom_range(0, 7);
                stall_left <= n;
                m_tready   <= (n == 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= (stall_left == 1);
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    int idle_cnt = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // ---------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------
    req_t dir_tab [$];

    initial begin
        for (int i = 0; i < REG_WORDS_DEF; i++) regs[i] = 32'h0;
        regs[W_MODE] = MODE_RST;

        // directed table: reset values and special words carry typed-in results
        dir_tab = '{
            mk_lit(A_MODE, 3'd4, MODE_RST),
            mk_lit(A_MODE, 3'd1, 32'h0000_000F),
            mk_lit(16'h0003, 3'd1, 32'h0000_00D9),
            mk_lit(A_STS1, 3'd4, 32'h0),
            mk_lit(16'h1000, 3'd4, 32'h0),
            mk_lit(16'hFFFF, 3'd7, 32'h0),
            mk(FN_WRITE, A_STS0, 32'hFFFF_FFFF, 3'd4),
            mk(FN_READ, A_STS0, 32'h0, 3'd4),
            mk(FN_WRITE, A_MODE, 32'hFFFF_FFFF, 3'd4),
            mk(FN_WRITE, A_MODE, 32'h5000_0000, 3'd0),
            mk(FN_WRITE, A_IMASK, 32'hFFFF_FFFF, 3'd4),
            mk(FN_WRITE, ctl_of(0) + 16'h4, 32'h1FFF_FFFF, 3'd4),
            mk(FN_WRITE, ctl_of(0) + 16'h8, 32'h0123_4567, 3'd4),
            mk(FN_WRITE, ctl_of(0) + 16'hC, 32'h89AB_CDEF, 3'd4),
            mk(FN_WRITE, ctl_of(0), {4'h0, CODE_SEND, 24'h3F_0000}, 3'd4),
            mk(FN_WRITE, ctl_of(1), {4'h0, CODE_EMPTY, 24'h0}, 3'd4),
            mk_frame(29'h1FFF_FFFF, 1'b1, 1'b1, 1'b1, 4'hF, ~64'h0),
            mk_frame(29'h1FFF_FFFF, 1'b1, 1'b1, 1'b0, 4'hF, ~64'h0),
            mk(FN_READ, ctl_of(1), 32'h0, 3'd4),
            mk(FN_WRITE, A_FLAGS, 32'hFFFF_FFFF, 3'd4),
            mk(FN_WRITE, 16'h0042, 32'hA5A5_A5A5, 3'd3),
            mk(FN_READ, 16'h0041, 32'h0, 3'd7),
            mk(FN_WRITE, A_CTRL1, B_LOOP, 3'd4),
            mk(FN_WRITE, ctl_of(40), {4'h0, CODE_EMPTY, 24'h0}, 3'd4),
            mk(FN_WRITE, ctl_of(95), {4'h0, CODE_SEND, 24'h08_0000}, 3'd4)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        set_bus(1'b1);

        foreach (dir_tab[i]) push_req(dir_tab[i]);
        push_req(mk(FN_NONE, 16'h0, 32'h0, 3'd4));

        // four phases: bus detached/attached, one phase without any idling
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_bus(ph[0]);
            no_idle = (ph == 2);
            for (int i = 0; i < 120; i++) push_req(rand_req());
        end

        s_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d reads, %0d writes, %0d frames in; %0d results checked",
                 n_rd, n_wr, n_fr, n_resp);
        $display("frames sent %0d, loopback deliveries %0d, receive fills %0d",
                 n_bus, n_loop, n_rx);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> can_message_buffer_controller_unit.f
rtl/cmbc_pkg.sv
rtl/cmbc_ctrl.sv
rtl/cmbc_dp.sv
rtl/can_message_buffer_controller_unit.sv
tb/sv/tb.sv
